// ===== rtl/ira_pkg.sv =====
// ----------------------------------------------------------------------------
// ira_pkg: shared types and constants of the identifier range allocator
// Holds the table size, the command and status codes, the operation codes
// that steer the range cells, and the record of one free range.
// ----------------------------------------------------------------------------
package ira_pkg;

  localparam int unsigned MaxRanges = 16;
  localparam int unsigned IdW       = 32;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_NONE   = 3'd1,
    STAT_SPAN   = 3'd2,
    STAT_DOUBLE = 3'd3,
    STAT_FULL   = 3'd4
  } status_e;

  typedef enum logic {
    REG_ID_FIRST = 1'b0,
    REG_ID_LAST  = 1'b1
  } reg_idx_e;

  // The operation that a range cell applies to its entry.
  typedef enum logic [3:0] {
    CELL_HOLD  = 4'd0,
    CELL_NEXT  = 4'd1,  // take the entry of the right neighbor
    CELL_PREV  = 4'd2,  // take the entry of the left neighbor
    CELL_LOAD  = 4'd3,  // load both bounds from the broadcast bus
    CELL_LOW   = 4'd4,
    CELL_HIGH  = 4'd5,
    CELL_MERGE = 4'd6,  // high bound from the right neighbor
    CELL_INC   = 4'd7,
    CELL_CLEAR = 4'd8
  } cell_op_e;

  typedef struct packed {
    logic           valid;
    logic [IdW-1:0] low;
    logic [IdW-1:0] high;
  } range_t;

  typedef struct packed {
    logic hit;     // id lies at or below high + 1
    logic adj_hi;  // id equals high + 1
    logic adj_lo;  // id + 1 equals low
    logic below;   // id lies below low
  } cell_flags_t;

endpackage

// ===== rtl/id_range_allocator_core.sv =====
// ----------------------------------------------------------------------------
// id_range_allocator_core: identifier allocator over a sorted free range table
// The two steps of every beat: the table compare at acceptance in S_IDLE,
// then the table update in S_APPLY, which registers the result beat and
// waits while the output stalls. No new beat is taken until it is applied.
// Reset: the table holds one range [1, 0xFFFFFFFF]; a write to either span
// register makes it the single range [id_first, id_last], or empties it if last < first.
// ----------------------------------------------------------------------------
module id_range_allocator_core
  import ira_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [IdW-1:0] cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           in_cmd_i,
  input  logic [IdW-1:0] in_release_id_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           out_ok_o,
  output logic [2:0]     out_status_o,
  output logic [IdW-1:0] out_granted_id_o
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [IdW-1:0] id_first_q, id_last_q;
  logic [IdW-1:0] cfg_first, cfg_last;

  range_t         ent     [MaxRanges];
  range_t         nxt     [MaxRanges];
  range_t         prv     [MaxRanges];
  range_t         rst_val [MaxRanges];
  cell_flags_t    flags   [MaxRanges];
  cell_op_e       ops     [MaxRanges];
  logic [IdW-1:0] bcast_lo, bcast_hi;

  logic [MaxRanges-1:0] valid_v, hit_v, adj_hi_v, adj_lo_v, below_v;
  logic [MaxRanges-1:0] first_v, first_inv, pos_v;

  // Decision held between acceptance and update.
  logic                 cmd_q;
  logic [IdW-1:0]       id_q;
  logic [MaxRanges-1:0] pos_q, after_q;
  logic                 hit_q, adj_hi_q, adj_lo_q, below_q, merge_q, span_bad_q;

  logic                 accept, apply;
  logic [MaxRanges-1:0] after_d;
  status_e              status;
  logic [IdW-1:0]       granted;

  logic                 out_valid_q;
  logic                 out_ok_q;
  logic [2:0]           out_status_q;
  logic [IdW-1:0]       out_granted_q;

  // ---------------------------------------------------------------- cells
  for (genvar i = 0; i < MaxRanges; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign rst_val[i] = '{valid: 1'b1, low: IdW'(1), high: {IdW{1'b1}}};
      assign prv[i]     = '0;
    end else begin : g_rest
      assign rst_val[i] = '0;
      assign prv[i]     = ent[i-1];
    end
    if (i == MaxRanges - 1) begin : g_last
      assign nxt[i] = '0;
    end else begin : g_inner
      assign nxt[i] = ent[i+1];
    end

    ira_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .rst_val_i  (rst_val[i]),
      .op_i       (ops[i]),
      .bcast_lo_i (bcast_lo),
      .bcast_hi_i (bcast_hi),
      .next_i     (nxt[i]),
      .prev_i     (prv[i]),
      .id_i       (in_release_id_i),
      .ent_o      (ent[i]),
      .flags_o    (flags[i])
    );

    assign valid_v[i]  = ent[i].valid;
    assign hit_v[i]    = flags[i].hit;
    assign adj_hi_v[i] = flags[i].adj_hi;
    assign adj_lo_v[i] = flags[i].adj_lo;
    assign below_v[i]  = flags[i].below;
  end

  // ------------------------------------------------------- acceptance step
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // The valid entries form a prefix, so the first free slot follows it.
  assign first_v   = hit_v & (~hit_v + {{(MaxRanges-1){1'b0}}, 1'b1});
  assign first_inv = ~valid_v & {valid_v[MaxRanges-2:0], 1'b1};
  assign pos_v     = (|hit_v) ? first_v : first_inv;
  assign after_d   = ~(pos_v - {{(MaxRanges-1){1'b0}}, 1'b1}) & ~pos_v;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= in_cmd_i;
      id_q       <= in_release_id_i;
      pos_q      <= pos_v;
      after_q    <= after_d;
      hit_q      <= |hit_v;
      adj_hi_q   <= |(first_v & adj_hi_v);
      adj_lo_q   <= |(first_v & adj_lo_v);
      below_q    <= |(first_v & below_v);
      merge_q    <= |(first_v & {1'b0, adj_lo_v[MaxRanges-1:1]});
      span_bad_q <= (in_release_id_i < id_first_q) || (in_release_id_i > id_last_q);
    end
  end

  // ---------------------------------------------------------- update step
  assign apply = (state_q == S_APPLY) && (!out_valid_q || !out_stall_i);

  assign cfg_first = (cfg_idx_i == REG_ID_FIRST) ? cfg_wdata_i : id_first_q;
  assign cfg_last  = (cfg_idx_i == REG_ID_LAST)  ? cfg_wdata_i : id_last_q;

  always_comb begin
    for (int i = 0; i < MaxRanges; i++) begin
      ops[i] = CELL_HOLD;
    end
    bcast_lo = id_q;
    bcast_hi = id_q;
    status   = STAT_OK;
    granted  = '0;

    if (cfg_we_i) begin
      // A span write rebuilds the table as one range, or empties it.
      bcast_lo = cfg_first;
      bcast_hi = cfg_last;
      for (int i = 0; i < MaxRanges; i++) begin
        ops[i] = CELL_CLEAR;
      end
      if (cfg_last >= cfg_first) begin
        ops[0] = CELL_LOAD;
      end
    end else if (apply) begin
      if (cmd_q == CMD_ALLOC) begin
        if (!valid_v[0]) begin
          status = STAT_NONE;
        end else begin
          granted = ent[0].low;
          if (ent[0].low == ent[0].high) begin
            for (int i = 0; i < MaxRanges; i++) begin
              ops[i] = CELL_NEXT;
            end
          end else begin
            ops[0] = CELL_INC;
          end
        end
      end else if (span_bad_q) begin
        status = STAT_SPAN;
      end else if (hit_q && adj_hi_q) begin
        for (int i = 0; i < MaxRanges; i++) begin
          if (pos_q[i]) begin
            ops[i] = merge_q ? CELL_MERGE : CELL_HIGH;
          end else if (after_q[i] && merge_q) begin
            ops[i] = CELL_NEXT;
          end
        end
      end else if (hit_q && adj_lo_q) begin
        for (int i = 0; i < MaxRanges; i++) begin
          if (pos_q[i]) begin
            ops[i] = CELL_LOW;
          end
        end
      end else if (hit_q && !below_q) begin
        status = STAT_DOUBLE;
      end else if (valid_v[MaxRanges-1]) begin
        status = STAT_FULL;
      end else begin
        // Insert a one-id range at the chosen slot and push the rest right.
        for (int i = 0; i < MaxRanges; i++) begin
          if (pos_q[i]) begin
            ops[i] = CELL_LOAD;
          end else if (after_q[i]) begin
            ops[i] = CELL_PREV;
          end
        end
      end
    end
  end

  // ------------------------------------------------------- control state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_APPLY;
      S_APPLY: if (apply) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      id_first_q  <= IdW'(1);
      id_last_q   <= {IdW{1'b1}};
    end else begin
      state_q <= state_d;
      if (apply) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        id_first_q <= cfg_first;
        id_last_q  <= cfg_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      out_ok_q      <= (status == STAT_OK);
      out_status_q  <= status;
      out_granted_q <= granted;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_ok_o         = out_ok_q;
  assign out_status_o     = out_status_q;
  assign out_granted_id_o = out_granted_q;

endmodule

// ===== rtl/ira_cell.sv =====
// ----------------------------------------------------------------------------
// ira_cell: one entry of the free range table
// Holds one range, compares it against the incoming identifier and takes
// its neighbor's entry when the table shifts.
// ----------------------------------------------------------------------------
module ira_cell
  import ira_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  range_t         rst_val_i,
  input  cell_op_e       op_i,
  input  logic [IdW-1:0] bcast_lo_i,
  input  logic [IdW-1:0] bcast_hi_i,
  input  range_t         next_i,
  input  range_t         prev_i,
  input  logic [IdW-1:0] id_i,
  output range_t         ent_o,
  output cell_flags_t    flags_o
);

  range_t         ent_q, ent_d;
  logic [IdW:0]   high_p1;
  logic [IdW:0]   id_p1;

  // Comparisons are made one bit wider so that no bound wraps.
  assign high_p1 = {1'b0, ent_q.high} + {{IdW{1'b0}}, 1'b1};
  assign id_p1   = {1'b0, id_i} + {{IdW{1'b0}}, 1'b1};

  assign flags_o.hit    = ent_q.valid && ({1'b0, id_i} <= high_p1);
  assign flags_o.adj_hi = ent_q.valid && ({1'b0, id_i} == high_p1);
  assign flags_o.adj_lo = ent_q.valid && (id_p1 == {1'b0, ent_q.low});
  assign flags_o.below  = ent_q.valid && (id_i < ent_q.low);

  always_comb begin
    ent_d = ent_q;
    unique case (op_i)
      CELL_HOLD:  ent_d = ent_q;
      CELL_NEXT:  ent_d = next_i;
      CELL_PREV:  ent_d = prev_i;
      CELL_LOAD: begin
        ent_d.valid = 1'b1;
        ent_d.low   = bcast_lo_i;
        ent_d.high  = bcast_hi_i;
      end
      CELL_LOW:   ent_d.low   = bcast_lo_i;
      CELL_HIGH:  ent_d.high  = bcast_hi_i;
      CELL_MERGE: ent_d.high  = next_i.high;
      CELL_INC:   ent_d.low   = ent_q.low + {{(IdW-1){1'b0}}, 1'b1};
      CELL_CLEAR: ent_d.valid = 1'b0;
      default:    ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= rst_val_i;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

// ===== test/id_range_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_range_allocator_core_tb: self-checking bench for the id range allocator
// Request beats come from a queue that the stimulus process fills. A second
// copy of the free range table is updated as each request beat is accepted,
// and every response beat is compared with the oldest predicted response.
// The span registers are rewritten between phases once the block is idle.
// ----------------------------------------------------------------------------
module id_range_allocator_core_tb;
  import ira_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int ReportMax  = 10;

  typedef struct packed {
    cmd_e           cmd;
    logic [IdW-1:0] rid;
  } id_req_t;

  typedef struct packed {
    logic           ok;
    status_e        status;
    logic [IdW-1:0] granted;
  } id_rsp_t;

  logic           clk_i           = 1'b0;
  logic           rst_ni          = 1'b0;
  logic           cfg_we_i        = 1'b0;
  logic           cfg_idx_i       = 1'b0;
  logic [IdW-1:0] cfg_wdata_i     = '0;
  logic           in_valid_i      = 1'b0;
  logic           in_stall_o;
  logic           in_cmd_i        = 1'b0;
  logic [IdW-1:0] in_release_id_i = '0;
  logic           out_valid_o;
  logic           out_stall_i     = 1'b0;
  logic           out_ok_o;
  logic [2:0]     out_status_o;
  logic [IdW-1:0] out_granted_id_o;

  id_range_allocator_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_cmd_i         (in_cmd_i),
    .in_release_id_i  (in_release_id_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_ok_o         (out_ok_o),
    .out_status_o     (out_status_o),
    .out_granted_id_o (out_granted_id_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the span and the free range table.
  logic [IdW-1:0] span_lo = 32'd1;
  logic [IdW-1:0] span_hi = 32'hFFFF_FFFF;
  logic [IdW-1:0] free_lo [MaxRanges];
  logic [IdW-1:0] free_hi [MaxRanges];
  int             free_cnt;

  id_req_t pending_req_q[$];
  id_rsp_t expected_rsp_q[$];
  id_req_t next_req;
  id_rsp_t oldest_rsp;
  logic    beat_taken = 1'b0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      error_cnt = 0;
  int      cycle_cnt = 0;

  function automatic void rebuild_table();
    for (int i = 0; i < MaxRanges; i++) begin
      free_lo[i] = '0;
      free_hi[i] = '0;
    end
    if (span_hi < span_lo) begin
      free_cnt = 0;
    end else begin
      free_lo[0] = span_lo;
      free_hi[0] = span_hi;
      free_cnt   = 1;
    end
  endfunction

  function automatic void drop_range(int pos);
    for (int i = pos; i + 1 < free_cnt; i++) begin
      free_lo[i] = free_lo[i+1];
      free_hi[i] = free_hi[i+1];
    end
    free_cnt--;
    free_lo[free_cnt] = '0;
    free_hi[free_cnt] = '0;
  endfunction

  function automatic status_e insert_range(int pos, logic [IdW-1:0] id);
    if (free_cnt >= MaxRanges) return STAT_FULL;
    for (int i = free_cnt; i > pos; i--) begin
      free_lo[i] = free_lo[i-1];
      free_hi[i] = free_hi[i-1];
    end
    free_lo[pos] = id;
    free_hi[pos] = id;
    free_cnt++;
    return STAT_OK;
  endfunction

  // All "plus one" compares are done at 33 bits so nothing wraps.
  function automatic status_e return_id(logic [IdW-1:0] id);
    logic [IdW:0] id_inc;
    id_inc = {1'b0, id} + 33'd1;
    if (id < span_lo || id > span_hi) return STAT_SPAN;
    for (int i = 0; i < free_cnt; i++) begin
      if ({1'b0, id} == {1'b0, free_hi[i]} + 33'd1) begin
        if (i + 1 < free_cnt && {1'b0, free_lo[i+1]} == id_inc) begin
          free_hi[i] = free_hi[i+1];
          drop_range(i + 1);
        end else begin
          free_hi[i] = id;
        end
        return STAT_OK;
      end
      if (id_inc == {1'b0, free_lo[i]}) begin
        free_lo[i] = id;
        return STAT_OK;
      end
      if (id < free_lo[i]) return insert_range(i, id);
      if (id <= free_hi[i]) return STAT_DOUBLE;
    end
    return insert_range(free_cnt, id);
  endfunction

  function automatic id_rsp_t predict_rsp(cmd_e cmd, logic [IdW-1:0] id);
    id_rsp_t rsp;
    rsp.granted = '0;
    if (cmd == CMD_ALLOC) begin
      if (free_cnt == 0) begin
        rsp.status = STAT_NONE;
      end else begin
        rsp.granted = free_lo[0];
        if (free_lo[0] == free_hi[0]) drop_range(0);
        else free_lo[0] = free_lo[0] + 32'd1;
        rsp.status = STAT_OK;
      end
    end else begin
      rsp.status = return_id(id);
    end
    rsp.ok = (rsp.status == STAT_OK);
    return rsp;
  endfunction

  task automatic note_error(string msg);
    error_cnt++;
    if (error_cnt <= ReportMax) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Driver: a beat holds until it is taken, then the next one may follow.
  always @(negedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    if (!in_valid_i || beat_taken) begin
      if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_req_q.pop_front();
        in_valid_i      <= 1'b1;
        in_cmd_i        <= next_req.cmd;
        in_release_id_i <= next_req.rid;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: the response side is checked before the request side is
  // predicted, so a same-edge push and pop are always ordered.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          note_error($sformatf("unexpected beat: ok=%0b status=%0d id=%h",
                               out_ok_o, out_status_o, out_granted_id_o));
        end else begin
          oldest_rsp = expected_rsp_q.pop_front();
          if (out_ok_o !== oldest_rsp.ok || out_status_o !== oldest_rsp.status ||
              out_granted_id_o !== oldest_rsp.granted) begin
            note_error($sformatf("exp ok=%0b status=%0d id=%h, got ok=%0b status=%0d id=%h",
                                 oldest_rsp.ok, oldest_rsp.status, oldest_rsp.granted,
                                 out_ok_o, out_status_o, out_granted_id_o));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_rsp_q.push_back(predict_rsp(cmd_e'(in_cmd_i), in_release_id_i));
      end
    end
    beat_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_req(cmd_e cmd, logic [IdW-1:0] id);
    id_req_t req;
    req.cmd = cmd;
    req.rid = id;
    pending_req_q.push_back(req);
  endtask

  // Waits until every beat is sent and answered.
  // The bus is sampled at the rising edge, after the driver has settled it.
  task automatic wait_idle();
    while (pending_req_q.size() != 0 || in_valid_i || expected_rsp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [IdW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ID_FIRST) span_lo = value;
    else span_hi = value;
    rebuild_table();
  endtask

  // Mixed traffic: release ids cluster around the low end of the span, where
  // allocations happen, with a few near the top end and a few anywhere.
  task automatic gen_mix(int count, int alloc_pct);
    logic [IdW-1:0] window;
    logic [IdW-1:0] id;
    int             pick;
    window = (span_hi - span_lo > 32'd80) ? 32'd80 : span_hi - span_lo;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < alloc_pct) begin
        push_req(CMD_ALLOC, $urandom);
      end else begin
        pick = $urandom_range(99);
        if (pick < 10) id = $urandom;
        else if (pick < 20) id = span_hi + $urandom_range(2) - 32'd1;
        else id = span_lo + $urandom_range(window + 32'd4) - 32'd2;
        push_req(CMD_RELEASE, id);
      end
    end
  endtask

  initial begin
    rebuild_table();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Default span: insert, extend upward, merge, out of span, double free.
    repeat (3) push_req(CMD_ALLOC, '0);
    push_req(CMD_RELEASE, 32'd1);
    push_req(CMD_RELEASE, 32'd2);
    push_req(CMD_RELEASE, 32'd3);
    push_req(CMD_RELEASE, 32'd0);
    push_req(CMD_RELEASE, 32'hFFFF_FFFF);
    wait_idle();

    // Top of the id space: exhaustion, insert into an empty table, extend down.
    write_reg(REG_ID_FIRST, 32'hFFFF_FFFE);
    repeat (3) push_req(CMD_ALLOC, 32'hFFFF_FFFF);
    push_req(CMD_RELEASE, 32'hFFFF_FFFF);
    push_req(CMD_RELEASE, 32'hFFFF_FFFE);
    push_req(CMD_RELEASE, 32'hFFFF_FFFD);
    wait_idle();

    // Empty span: last below first.
    write_reg(REG_ID_LAST, 32'd0);
    push_req(CMD_ALLOC, '0);
    push_req(CMD_RELEASE, 32'd0);
    push_req(CMD_RELEASE, 32'hFFFF_FFFE);
    wait_idle();

    // Single-id span at zero.
    write_reg(REG_ID_FIRST, 32'd0);
    push_req(CMD_ALLOC, '0);
    push_req(CMD_ALLOC, '0);
    push_req(CMD_RELEASE, 32'd0);
    push_req(CMD_RELEASE, 32'd0);
    push_req(CMD_RELEASE, 32'd1);
    wait_idle();

    // Small span, heavy allocation then scattered releases to fill the table.
    write_reg(REG_ID_FIRST, $urandom_range(8));
    write_reg(REG_ID_LAST, span_lo + 32'd50);
    gen_mix(50, 90);
    gen_mix(60, 15);
    wait_idle();

    send_idle_pct = 48;
    write_reg(REG_ID_LAST, 32'hFFFF_FFFF);
    write_reg(REG_ID_FIRST, 32'hFFFF_FFFF - $urandom_range(60, 20));
    gen_mix(40, 90);
    gen_mix(70, 30);
    wait_idle();

    send_idle_pct = 0;
    stall_pct     = 48;
    write_reg(REG_ID_FIRST, $urandom_range(32'hFFFF_FF00));
    write_reg(REG_ID_LAST, span_lo + $urandom_range(100, 20));
    gen_mix(40, 80);
    gen_mix(70, 45);
    wait_idle();

    send_idle_pct = 35;
    stall_pct     = 35;
    write_reg(REG_ID_FIRST, 32'd0);
    write_reg(REG_ID_LAST, 32'hFFFF_FFFF);
    gen_mix(30, 95);
    gen_mix(80, 40);
    wait_idle();

    repeat (10) @(negedge clk_i);
    if (error_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
